@@ hw/rtl/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and codes of the sparse set slot pool
// Operation and status codes, field widths and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int OP_W   = 3;
   localparam int ST_W   = 3;
   localparam int ENT_W  = 11;
   localparam int SLOT_W = 10;
   localparam int CAP_W  = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CREATE        = 3'd0;
   localparam logic [OP_W-1:0] OP_GET_OR_CREATE = 3'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP        = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_ENTITY = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE_SLOT   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR         = 3'd5;

   // Status codes.
   localparam logic [ST_W-1:0] ST_OK          = 3'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL        = 3'd2;
   localparam logic [ST_W-1:0] ST_SLOT_RANGE  = 3'd3;
   localparam logic [ST_W-1:0] ST_PRESENT     = 3'd4;

   // How the datapath fills the result word.
   typedef enum logic [1:0] {
      RK_BARE    = 2'd0,
      RK_FOUND   = 2'd1,
      RK_CREATED = 2'd2,
      RK_REMOVED = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic             accept;
      logic             create;
      logic             victim;
      logic             remove;
      logic             fixup;
      logic             sweep_begin;
      logic             sweep;
      logic             respond;
      rsp_kind_type     rsp_kind;
      logic [ST_W-1:0]  rsp_status;
   } ssp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            ent_ok;
      logic            present;
      logic            cur_le_count;
      logic            full;
      logic            sidx_ok;
      logic            sweep_last;
   } ssp_stat_type;

endpackage

@@ hw/rtl/ssp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssp_ctrl: controller of the sparse set slot pool
// Sequences each operation through decide, removals also through remove and
// fix-up; runs the clearing pass of the sparse map after reset and on clear.
// ----------------------------------------------------------------------------
module ssp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ssp_pkg::ssp_stat_type stat,
   output ssp_pkg::ssp_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECIDE = 6'b000010,
      S_REMOVE = 6'b000100,
      S_FIXUP  = 6'b001000,
      S_CLEAR  = 6'b010000,
      S_INIT   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.rsp_kind   = ssp_pkg::RK_BARE;
      cmd.rsp_status = ssp_pkg::ST_OK;
      state_in       = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            if (stat.op == ssp_pkg::OP_CREATE || stat.op == ssp_pkg::OP_GET_OR_CREATE ||
                stat.op == ssp_pkg::OP_LOOKUP) begin
               cmd.respond = 1'b1;
               priority if (!stat.ent_ok) begin
                  cmd.rsp_status = ssp_pkg::ST_NOT_FOUND;
               end else if (stat.present) begin
                  cmd.rsp_kind   = ssp_pkg::RK_FOUND;
                  cmd.rsp_status = (stat.op == ssp_pkg::OP_CREATE) ?
                                   ssp_pkg::ST_PRESENT : ssp_pkg::ST_OK;
               end else if (stat.op == ssp_pkg::OP_LOOKUP) begin
                  cmd.rsp_status = ssp_pkg::ST_NOT_FOUND;
               end else if (stat.full) begin
                  cmd.rsp_status = ssp_pkg::ST_FULL;
               end else begin
                  cmd.create   = 1'b1;
                  cmd.rsp_kind = ssp_pkg::RK_CREATED;
               end
            end else if (stat.op == ssp_pkg::OP_REMOVE_ENTITY) begin
               if (!stat.ent_ok || !stat.present || !stat.cur_le_count) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = ssp_pkg::ST_NOT_FOUND;
               end else begin
                  cmd.victim = 1'b1;
                  state_in   = S_REMOVE;
               end
            end else if (stat.op == ssp_pkg::OP_REMOVE_SLOT) begin
               if (!stat.sidx_ok) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = ssp_pkg::ST_SLOT_RANGE;
               end else begin
                  cmd.victim = 1'b1;
                  state_in   = S_REMOVE;
               end
            end else if (stat.op == ssp_pkg::OP_CLEAR) begin
               cmd.sweep_begin = 1'b1;
               state_in        = S_CLEAR;
            end else begin
               cmd.respond = 1'b1;
            end
         end
         S_REMOVE: begin
            cmd.remove = 1'b1;
            state_in   = S_FIXUP;
         end
         S_FIXUP: begin
            cmd.fixup    = 1'b1;
            cmd.respond  = 1'b1;
            cmd.rsp_kind = ssp_pkg::RK_REMOVED;
            state_in     = S_IDLE;
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/ssp_datapath.sv @@
// ----------------------------------------------------------------------------
// ssp_datapath: storage and result logic of the sparse set slot pool
// Holds the sparse map, the dense array, the live count and the capacity
// register, and builds the result word under the controller's commands.
// ----------------------------------------------------------------------------
module ssp_datapath #(
   parameter int MAX_ENTITIES = 1024,
   parameter int MAX_SLOTS    = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ssp_pkg::ssp_cmd_type             cmd,
   output ssp_pkg::ssp_stat_type            stat,
   input  logic [ssp_pkg::OP_W-1:0]         req_operation,
   input  logic [ssp_pkg::ENT_W-1:0]        req_entity_id,
   input  logic [ssp_pkg::SLOT_W-1:0]       req_slot_index,
   input  logic                             csr_we,
   input  logic [ssp_pkg::CAP_W-1:0]        csr_wdata,
   output logic                             rsp_valid,
   output logic [ssp_pkg::ST_W-1:0]         rsp_status,
   output logic                             rsp_created,
   output logic [ssp_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [ssp_pkg::ENT_W-1:0]        rsp_entity_at_slot,
   output logic                             rsp_moved,
   output logic [ssp_pkg::SLOT_W-1:0]       rsp_moved_from,
   output logic [ssp_pkg::CAP_W-1:0]        rsp_live_count
);

   localparam int EIDX_W = $clog2(MAX_ENTITIES);
   localparam int SIDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   // Sparse map holds slot plus one per entity; dense array holds the entity per slot.
   logic [CNT_W-1:0]           e2s_mem [MAX_ENTITIES];
   logic [ssp_pkg::ENT_W-1:0]  s2e_mem [MAX_SLOTS];

   logic [CNT_W-1:0]           cur_ff;
   logic [ssp_pkg::ENT_W-1:0]  dense_rd_ff;
   logic [SIDX_W-1:0]          dense_raddr;

   logic                       e2s_we;
   logic [EIDX_W-1:0]          e2s_waddr;
   logic [CNT_W-1:0]           e2s_wdata;
   logic                       s2e_we;
   logic [SIDX_W-1:0]          s2e_waddr;
   logic [ssp_pkg::ENT_W-1:0]  s2e_wdata;

   logic [ssp_pkg::OP_W-1:0]   op_ff;
   logic [ssp_pkg::ENT_W-1:0]  ent_ff;
   logic [ssp_pkg::SLOT_W-1:0] sidx_ff;

   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [EIDX_W-1:0]          sweep_ff;
   logic [ssp_pkg::CAP_W-1:0]  cap_ff;
   logic [31:0]                cap_eff;

   logic [SIDX_W-1:0]          vslot_ff;
   logic [ssp_pkg::ENT_W-1:0]  vent_ff;
   logic [ssp_pkg::ENT_W-1:0]  last_ff;
   logic                       moved_ff;
   logic                       moved_in;
   logic [ssp_pkg::SLOT_W-1:0] from_ff;
   logic                       vent_ok;
   logic                       last_ok;

   // Status towards the controller.
   assign cap_eff = (32'(cap_ff) > MAX_SLOTS) ? MAX_SLOTS : 32'(cap_ff);

   always_comb begin
      stat.op           = op_ff;
      stat.ent_ok       = (ent_ff != '0) && (32'(ent_ff) <= MAX_ENTITIES);
      stat.present      = (cur_ff != '0);
      stat.cur_le_count = (cur_ff <= count_ff);
      stat.full         = (32'(count_ff) >= cap_eff);
      stat.sidx_ok      = (32'(sidx_ff) < 32'(count_ff)) && (32'(sidx_ff) < MAX_SLOTS);
      stat.sweep_last   = (sweep_ff == EIDX_W'(MAX_ENTITIES - 1));
   end

   assign vent_ok  = (vent_ff != '0) && (32'(vent_ff) <= MAX_ENTITIES);
   assign last_ok  = (last_ff != '0) && (32'(last_ff) <= MAX_ENTITIES);
   assign moved_in = (32'(vslot_ff) < 32'(count_in));

   // Live count.
   always_comb begin
      count_in = count_ff;
      if (cmd.create) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.sweep_begin) begin
         count_in = '0;
      end
   end

   // Memory write and read address selection.
   always_comb begin
      e2s_we    = 1'b0;
      e2s_waddr = sweep_ff;
      e2s_wdata = '0;
      s2e_we    = 1'b0;
      s2e_waddr = SIDX_W'(count_ff);
      s2e_wdata = ent_ff;
      if (cmd.create) begin
         e2s_we    = 1'b1;
         e2s_waddr = EIDX_W'(ent_ff - ssp_pkg::ENT_W'(1));
         e2s_wdata = count_ff + CNT_W'(1);
         s2e_we    = 1'b1;
      end else if (cmd.remove) begin
         // The last entry lands in the hole; a write into the freed last slot is harmless.
         e2s_we    = vent_ok;
         e2s_waddr = EIDX_W'(vent_ff - ssp_pkg::ENT_W'(1));
         s2e_we    = 1'b1;
         s2e_waddr = vslot_ff;
         s2e_wdata = dense_rd_ff;
      end else if (cmd.fixup) begin
         e2s_we    = moved_ff && last_ok;
         e2s_waddr = EIDX_W'(last_ff - ssp_pkg::ENT_W'(1));
         e2s_wdata = CNT_W'(vslot_ff) + CNT_W'(1);
      end else if (cmd.sweep) begin
         e2s_we    = 1'b1;
      end
      dense_raddr = cmd.accept ? SIDX_W'(req_slot_index) : SIDX_W'(count_ff - CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (e2s_we) begin
         e2s_mem[e2s_waddr] <= e2s_wdata;
      end
      if (cmd.accept) begin
         cur_ff <= e2s_mem[EIDX_W'(req_entity_id - ssp_pkg::ENT_W'(1))];
      end
   end

   always_ff @(posedge clock) begin
      if (s2e_we) begin
         s2e_mem[s2e_waddr] <= s2e_wdata;
      end
      dense_rd_ff <= s2e_mem[dense_raddr];
   end

   // Item fields and removal bookkeeping.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_operation;
         ent_ff  <= req_entity_id;
         sidx_ff <= req_slot_index;
      end
      if (cmd.victim) begin
         if (op_ff == ssp_pkg::OP_REMOVE_SLOT) begin
            vslot_ff <= SIDX_W'(sidx_ff);
            vent_ff  <= dense_rd_ff;
         end else begin
            vslot_ff <= SIDX_W'(cur_ff - CNT_W'(1));
            vent_ff  <= ent_ff;
         end
      end
      if (cmd.remove) begin
         last_ff  <= dense_rd_ff;
         moved_ff <= moved_in;
         from_ff  <= moved_in ? ssp_pkg::SLOT_W'(count_in) : '0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sweep_ff  <= '0;
         cap_ff    <= ssp_pkg::CAP_RESET;
         rsp_valid <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rsp_valid <= cmd.respond;
         if (cmd.sweep_begin) begin
            sweep_ff <= '0;
         end else if (cmd.sweep) begin
            sweep_ff <= sweep_ff + EIDX_W'(1);
         end
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // Result word.
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status         <= cmd.rsp_status;
         rsp_created        <= 1'b0;
         rsp_slot           <= '0;
         rsp_entity_at_slot <= '0;
         rsp_moved          <= 1'b0;
         rsp_moved_from     <= '0;
         rsp_live_count     <= ssp_pkg::CAP_W'(count_in);
         unique case (cmd.rsp_kind)
            ssp_pkg::RK_FOUND: begin
               rsp_slot           <= ssp_pkg::SLOT_W'(cur_ff - CNT_W'(1));
               rsp_entity_at_slot <= ent_ff;
            end
            ssp_pkg::RK_CREATED: begin
               rsp_created        <= 1'b1;
               rsp_slot           <= ssp_pkg::SLOT_W'(count_ff);
               rsp_entity_at_slot <= ent_ff;
            end
            ssp_pkg::RK_REMOVED: begin
               rsp_slot           <= ssp_pkg::SLOT_W'(vslot_ff);
               rsp_entity_at_slot <= vent_ff;
               rsp_moved          <= moved_ff;
               rsp_moved_from     <= from_ff;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/sparse_set_slot_pool_top.sv @@
// ----------------------------------------------------------------------------
// sparse_set_slot_pool_top: sparse set of entity ids packed into slots
// Create, get-or-create, lookup, swap-remove by entity or by slot, and clear.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Create,
// get-or-create, lookup, unused codes and rejected removals go through the
// decide state before the result strobe; a successful removal also passes
// through the remove and fix-up states, since the sparse map has one port
// and is read once and written twice; clear sweeps the map, one map entry
// zeroed per cycle. After reset the block runs the same clearing pass with
// busy high. Each result is shown for exactly one cycle with rsp_valid and
// the receiver cannot stall it. The capacity register is always ready.
module sparse_set_slot_pool_top #(
   parameter int MAX_ENTITIES = 1024,
   parameter int MAX_SLOTS    = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ssp_pkg::OP_W-1:0]    req_operation,
   input  logic [ssp_pkg::ENT_W-1:0]   req_entity_id,
   input  logic [ssp_pkg::SLOT_W-1:0]  req_slot_index,
   output logic                        rsp_valid,
   output logic [ssp_pkg::ST_W-1:0]    rsp_status,
   output logic                        rsp_created,
   output logic [ssp_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [ssp_pkg::ENT_W-1:0]   rsp_entity_at_slot,
   output logic                        rsp_moved,
   output logic [ssp_pkg::SLOT_W-1:0]  rsp_moved_from,
   output logic [ssp_pkg::CAP_W-1:0]   rsp_live_count,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ssp_pkg::CAP_W-1:0]   csr_wdata
);

   ssp_pkg::ssp_cmd_type  cmd;
   ssp_pkg::ssp_stat_type stat;

   assign csr_ready = 1'b1;

   ssp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ssp_datapath #(
      .MAX_ENTITIES (MAX_ENTITIES),
      .MAX_SLOTS    (MAX_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_entity_id      (req_entity_id),
      .req_slot_index     (req_slot_index),
      .csr_we             (csr_valid && csr_ready),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_created        (rsp_created),
      .rsp_slot           (rsp_slot),
      .rsp_entity_at_slot (rsp_entity_at_slot),
      .rsp_moved          (rsp_moved),
      .rsp_moved_from     (rsp_moved_from),
      .rsp_live_count     (rsp_live_count)
   );

   // A result word only appears while the controller is back in idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // A lookup taken while idle answers with a result strobe after the decide state.
   a_lookup_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == ssp_pkg::OP_LOOKUP) |-> ##2 rsp_valid)
      else $error("lookup result missing");

   // A new slot is only ever reported with status ok and no move.
   a_created_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_created) |-> (rsp_status == ssp_pkg::ST_OK && !rsp_moved))
      else $error("created with bad status or move");

   // The live count never exceeds the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_SLOTS > 2047 || 32'(rsp_live_count) <= MAX_SLOTS))
      else $error("live count above slot count");

endmodule
